@@ design/fdc_pkg.sv @@
// Shared types, constants and helpers of the fan duty curve controller.
package fdc_pkg;

  // Number of fan channels and the width of a channel index
  localparam int CHANNELS = 2;
  localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int OP_W    = 3;
  localparam int TEMP_W  = 8;
  localparam int CHAN_W  = 3;
  localparam int REQ_W   = 8;
  localparam int DUTY_W  = 7;
  localparam int AGE_W   = 14;
  localparam int STEP_W  = 8;
  localparam int GEAR_W  = 7;
  localparam int PROD_W  = GEAR_W + STEP_W;
  localparam int CIDX_W  = 8;
  localparam int CDAT_W  = 14;

  localparam logic [AGE_W-1:0]  AGE_MAX  = {AGE_W{1'b1}};
  localparam logic [DUTY_W-1:0] DUTY_MAX = DUTY_W'(100);

  // Operation codes of an input word
  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_REPORT = 3'd1,
    OP_MANUAL = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_STEP   = 3'd4
  } op_t;

  // Configuration register indexes
  typedef enum logic [CIDX_W-1:0] {
    CFG_TEMP_LOW  = 8'd0,
    CFG_TEMP_HIGH = 8'd1,
    CFG_FLOOR     = 8'd2,
    CFG_CEILING   = 8'd3,
    CFG_FAILSAFE  = 8'd4,
    CFG_HYST      = 8'd5,
    CFG_STALE     = 8'd6,
    CFG_GEAR_STEP = 8'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp_low;
    logic signed [TEMP_W-1:0] temp_high;
    logic [DUTY_W-1:0]        duty_floor;
    logic [DUTY_W-1:0]        duty_ceiling;
    logic [DUTY_W-1:0]        failsafe_duty;
    logic [DUTY_W-1:0]        hysteresis_pct;
    logic [AGE_W-1:0]         stale_ticks;
    logic [STEP_W-1:0]        gear_step_permille;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    temp_low:           8'sd35,
    temp_high:          8'sd75,
    duty_floor:         7'd30,
    duty_ceiling:       7'd100,
    failsafe_duty:      7'd100,
    hysteresis_pct:     7'd3,
    stale_ticks:        14'd10000,
    gear_step_permille: 8'd35
  };

  // Temperature status handed to the curve unit
  typedef struct packed {
    logic                     fresh;
    logic signed [TEMP_W-1:0] temp;
    logic [PROD_W-1:0]        prod;
  } curve_t;

  // Saturate a percent value at 100
  function automatic logic [DUTY_W-1:0] cap100(input logic [REQ_W-1:0] v);
    logic [DUTY_W-1:0] r;
    r = (v > REQ_W'(DUTY_MAX)) ? DUTY_MAX : v[DUTY_W-1:0];
    return r;
  endfunction

endpackage

@@ design/fdc_ifs.sv @@
// Valid/ready channel interfaces of the fan duty curve controller.
interface fdc_in_if;
  logic                        valid;
  logic                        ready;
  logic [fdc_pkg::OP_W-1:0]    op;
  logic [fdc_pkg::TEMP_W-1:0]  temperature;
  logic [fdc_pkg::CHAN_W-1:0]  channel;
  logic [fdc_pkg::REQ_W-1:0]   duty_request;
  logic                        board_power_on;
  logic                        power_known;

  modport source(output valid, op, temperature, channel, duty_request, board_power_on,
                 power_known, input ready);
  modport sink(input valid, op, temperature, channel, duty_request, board_power_on,
               power_known, output ready);
endinterface

interface fdc_out_if;
  logic                        valid;
  logic                        ready;
  logic [fdc_pkg::CHAN_W-1:0]  fan_channel;
  logic [fdc_pkg::DUTY_W-1:0]  duty_pct;
  logic                        applied;
  logic                        temp_fresh;
  logic                        last;

  modport source(output valid, fan_channel, duty_pct, applied, temp_fresh, last,
                 input ready);
  modport sink(input valid, fan_channel, duty_pct, applied, temp_fresh, last,
               output ready);
endinterface

interface fdc_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [fdc_pkg::CIDX_W-1:0]  index;
  logic [fdc_pkg::CDAT_W-1:0]  data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ design/fdc_auto_duty.sv @@
// Automatic duty curve: failsafe, floor, ceiling and geared ramp, capped at 100.
module fdc_auto_duty (
  input  fdc_pkg::cfg_t                cfg,
  input  fdc_pkg::curve_t              cur,
  output logic [fdc_pkg::DUTY_W-1:0]   curve_pct
);

  logic [fdc_pkg::DUTY_W-1:0] gear_pct;
  logic [9:0]                 prod_lo;
  logic [17:0]                recip;
  logic [fdc_pkg::REQ_W-1:0]  ramp_sum;
  logic                       prod_big;

  // Ramp: floor + prod/10; prod/10 by reciprocal multiply, exact below 1000
  assign prod_big = (cur.prod >= fdc_pkg::PROD_W'(1000));
  assign prod_lo  = cur.prod[9:0];
  assign recip    = 18'(prod_lo) * 18'd205;
  assign gear_pct = recip[17:11];
  assign ramp_sum = fdc_pkg::REQ_W'(cfg.duty_floor) + fdc_pkg::REQ_W'(gear_pct);

  // Select the curve region
  always_comb begin
    if (!cur.fresh || (cur.temp == -8'sd1)) begin
      curve_pct = fdc_pkg::cap100(fdc_pkg::REQ_W'(cfg.failsafe_duty));
    end else if ($signed(cur.temp) <= $signed(cfg.temp_low)) begin
      curve_pct = fdc_pkg::cap100(fdc_pkg::REQ_W'(cfg.duty_floor));
    end else if ($signed(cur.temp) >= $signed(cfg.temp_high)) begin
      curve_pct = fdc_pkg::cap100(fdc_pkg::REQ_W'(cfg.duty_ceiling));
    end else if (prod_big) begin
      curve_pct = fdc_pkg::DUTY_MAX;
    end else begin
      curve_pct = fdc_pkg::cap100(ramp_sum);
    end
  end

endmodule

@@ design/fan_duty_curve_controller.sv @@
// Top level of the fan duty curve controller: input stage, state, result buffer.
//
//  channel   dir  handshake        word
//  in_bus    in   valid/ready      op, temperature, channel, duty_request, power flags
//  out_bus   out  valid/ready      fan_channel, duty_pct, applied, temp_fresh, last
//  cfg_bus   in   valid/ready=1    index, data (register write)
//
// Ticks, reports and manual commands pass the stage at one word per cycle while
// no step word waits there. A control step leaves CHANNELS result words, drained
// one per cycle through the single output port while out_bus.ready is high, and a
// further step waits in the stage until the last word is taken; a stalled output
// thus holds it there. Results pass the input stage and result buffer registers.
// Reset (rst_n low, synchronous) empties both and restores config and controller state.
module fan_duty_curve_controller (
  input  logic              clk,
  input  logic              rst_n,
  fdc_in_if.sink            in_bus,
  fdc_out_if.source         out_bus,
  fdc_cfg_if.sink           cfg_bus
);

  localparam int CH = fdc_pkg::CHANNELS;
  localparam logic [fdc_pkg::CH_W-1:0] LAST_IDX = fdc_pkg::CH_W'(CH - 1);

  typedef struct packed {
    logic [fdc_pkg::OP_W-1:0]          op;
    logic signed [fdc_pkg::TEMP_W-1:0] temperature;
    logic [fdc_pkg::CHAN_W-1:0]        channel;
    logic [fdc_pkg::REQ_W-1:0]         duty_request;
    logic                              board_power_on;
    logic                              power_known;
  } item_t;

  typedef struct packed {
    logic [fdc_pkg::DUTY_W-1:0] duty;
    logic                       applied;
  } res_t;

  // Input stage
  logic  stg_v_r;
  item_t stg_r;
  logic  stg_go;
  logic  buf_free;

  // Configuration and controller state
  fdc_pkg::cfg_t                     cfg_r, cfg_nxt;
  logic                              prev_pon_r, prev_pon_nxt;
  logic                              seen_r, seen_nxt;
  logic signed [fdc_pkg::TEMP_W-1:0] temp_r, temp_nxt;
  logic [fdc_pkg::AGE_W-1:0]         age_r, age_nxt;
  logic [CH-1:0]                     mm_r, mm_nxt;
  logic [fdc_pkg::DUTY_W-1:0]        man_r [CH];
  logic [fdc_pkg::DUTY_W-1:0]        man_nxt [CH];
  logic [fdc_pkg::DUTY_W-1:0]        app_r [CH];
  logic [fdc_pkg::DUTY_W-1:0]        app_nxt [CH];
  logic [fdc_pkg::PROD_W-1:0]        prod_r, prod_nxt;

  // Result buffer
  logic                       busy_r;
  logic [fdc_pkg::CH_W-1:0]   idx_r;
  logic                       fresh_r;
  res_t                       res_r [CH];
  res_t                       res_nxt [CH];

  logic                       is_step;
  logic                       fresh;
  logic                       pwr_off;
  logic                       pwr_rise;
  logic [fdc_pkg::DUTY_W-1:0] curve_pct;
  fdc_pkg::curve_t            cur;
  logic                       out_fire;

  logic signed [fdc_pkg::TEMP_W:0] diff_nxt;
  logic [fdc_pkg::GEAR_W-1:0]      gear_nxt;

  // Handshakes
  assign is_step       = (stg_r.op == fdc_pkg::OP_STEP);
  assign out_fire      = out_bus.valid && out_bus.ready;
  assign buf_free      = !busy_r || (out_bus.ready && (idx_r == LAST_IDX));
  assign stg_go        = stg_v_r && (!is_step || buf_free);
  assign in_bus.ready  = !stg_v_r || stg_go;
  assign cfg_bus.ready = 1'b1;

  // Step status
  assign fresh    = seen_r && (age_r <= cfg_r.stale_ticks);
  assign pwr_off  = stg_r.power_known && !stg_r.board_power_on;
  assign pwr_rise = stg_r.board_power_on && !prev_pon_r;

  assign cur.fresh = fresh;
  assign cur.temp  = temp_r;
  assign cur.prod  = prod_r;

  fdc_auto_duty u_auto (
    .cfg       (cfg_r),
    .cur       (cur),
    .curve_pct (curve_pct)
  );

  // Configuration writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_bus.valid) begin
      case (cfg_bus.index)
        fdc_pkg::CFG_TEMP_LOW:  cfg_nxt.temp_low           = cfg_bus.data[7:0];
        fdc_pkg::CFG_TEMP_HIGH: cfg_nxt.temp_high          = cfg_bus.data[7:0];
        fdc_pkg::CFG_FLOOR:     cfg_nxt.duty_floor         = cfg_bus.data[6:0];
        fdc_pkg::CFG_CEILING:   cfg_nxt.duty_ceiling       = cfg_bus.data[6:0];
        fdc_pkg::CFG_FAILSAFE:  cfg_nxt.failsafe_duty      = cfg_bus.data[6:0];
        fdc_pkg::CFG_HYST:      cfg_nxt.hysteresis_pct     = cfg_bus.data[6:0];
        fdc_pkg::CFG_STALE:     cfg_nxt.stale_ticks        = cfg_bus.data[13:0];
        fdc_pkg::CFG_GEAR_STEP: cfg_nxt.gear_step_permille = cfg_bus.data[7:0];
        default: ;
      endcase
    end
  end

  // Controller state update for the word in the stage
  always_comb begin
    logic [fdc_pkg::DUTY_W-1:0] tgt;
    logic [fdc_pkg::DUTY_W-1:0] delta;
    logic                       apply;
    logic                       mm_eff;
    prev_pon_nxt = prev_pon_r;
    seen_nxt     = seen_r;
    temp_nxt     = temp_r;
    age_nxt      = age_r;
    mm_nxt       = mm_r;
    man_nxt      = man_r;
    app_nxt      = app_r;
    res_nxt      = res_r;
    tgt          = '0;
    delta        = '0;
    apply        = 1'b0;
    mm_eff       = 1'b0;
    if (stg_go) begin
      case (stg_r.op)
        fdc_pkg::OP_TICK: begin
          if (age_r != fdc_pkg::AGE_MAX) age_nxt = age_r + 1'b1;
        end
        fdc_pkg::OP_REPORT: begin
          temp_nxt = stg_r.temperature;
          seen_nxt = 1'b1;
          age_nxt  = '0;
        end
        fdc_pkg::OP_MANUAL: begin
          for (int c = 0; c < CH; c++) begin
            if (stg_r.channel == fdc_pkg::CHAN_W'(c)) begin
              mm_nxt[c]  = 1'b1;
              man_nxt[c] = fdc_pkg::cap100(stg_r.duty_request);
            end
          end
        end
        fdc_pkg::OP_CLEAR: begin
          mm_nxt = '0;
        end
        fdc_pkg::OP_STEP: begin
          prev_pon_nxt = stg_r.board_power_on;
          for (int c = 0; c < CH; c++) begin
            mm_eff    = mm_r[c] && !pwr_rise;
            mm_nxt[c] = mm_eff;
            if (pwr_off) begin
              tgt   = '0;
              apply = (app_r[c] != tgt);
            end else if (mm_eff) begin
              tgt   = man_r[c];
              apply = (app_r[c] != tgt);
            end else begin
              tgt   = curve_pct;
              delta = (curve_pct > app_r[c]) ? (curve_pct - app_r[c])
                                             : (app_r[c] - curve_pct);
              apply = (delta >= cfg_r.hysteresis_pct);
            end
            if (apply) app_nxt[c] = tgt;
            res_nxt[c].duty    = apply ? tgt : app_r[c];
            res_nxt[c].applied = apply;
          end
        end
        default: ;
      endcase
    end
  end

  // Gear product for the ramp, kept in step with temperature and configuration
  assign diff_nxt = {temp_nxt[fdc_pkg::TEMP_W-1], temp_nxt}
                  - {cfg_nxt.temp_low[fdc_pkg::TEMP_W-1], cfg_nxt.temp_low};
  assign gear_nxt = diff_nxt[fdc_pkg::TEMP_W-1:1];
  assign prod_nxt = fdc_pkg::PROD_W'(gear_nxt)
                  * fdc_pkg::PROD_W'(cfg_nxt.gear_step_permille);

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r      <= fdc_pkg::CFG_RESET;
      prev_pon_r <= 1'b0;
      seen_r     <= 1'b0;
      temp_r     <= -8'sd1;
      age_r      <= '0;
      mm_r       <= '0;
      for (int c = 0; c < CH; c++) begin
        man_r[c] <= '0;
        app_r[c] <= '0;
      end
    end else begin
      cfg_r      <= cfg_nxt;
      prev_pon_r <= prev_pon_nxt;
      seen_r     <= seen_nxt;
      temp_r     <= temp_nxt;
      age_r      <= age_nxt;
      mm_r       <= mm_nxt;
      man_r      <= man_nxt;
      app_r      <= app_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  // Input stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (in_bus.ready) begin
      stg_v_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      stg_r.op             <= in_bus.op;
      stg_r.temperature    <= in_bus.temperature;
      stg_r.channel        <= in_bus.channel;
      stg_r.duty_request   <= in_bus.duty_request;
      stg_r.board_power_on <= in_bus.board_power_on;
      stg_r.power_known    <= in_bus.power_known;
    end
  end

  // Result buffer: loaded by a control step, drained one channel per word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (stg_go && is_step) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (out_fire) begin
      if (idx_r == LAST_IDX) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stg_go && is_step) begin
      fresh_r <= fresh;
    end
    res_r <= res_nxt;
  end

  // Output word
  assign out_bus.valid       = busy_r;
  assign out_bus.fan_channel = fdc_pkg::CHAN_W'(idx_r);
  assign out_bus.duty_pct    = res_r[idx_r].duty;
  assign out_bus.applied     = res_r[idx_r].applied;
  assign out_bus.temp_fresh  = fresh_r;
  assign out_bus.last        = (idx_r == LAST_IDX);

endmodule
